>>> src/lsq_pkg.sv
// Shared types, sizes and codes for the linked stack and queue transfer block.
// Used by every module in src except lsq_ram; depends on nothing else.
`timescale 1ns / 1ps
package lsq_pkg;

    localparam int POOL_DEPTH  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int PW          = $clog2(POOL_DEPTH);
    localparam int CW          = $clog2(POOL_DEPTH + 1);
    localparam int LIST_CAP    = (MAX_RESULTS < POOL_DEPTH) ? MAX_RESULTS : POOL_DEPTH;

    localparam logic [2:0] CMD_PUSH       = 3'd0;
    localparam logic [2:0] CMD_ENQUEUE    = 3'd1;
    localparam logic [2:0] CMD_STACK2QUE  = 3'd2;
    localparam logic [2:0] CMD_QUE2STACK  = 3'd3;
    localparam logic [2:0] CMD_LIST_STACK = 3'd4;
    localparam logic [2:0] CMD_LIST_QUEUE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        K_PUSH, K_ENQ, K_S2Q, K_Q2S, K_LSTK, K_LQUE, K_NONE
    } t_kind;

    typedef struct packed {
        logic [2:0]  command;
        logic [30:0] record_number;
        logic [63:0] given_name_low;
        logic [15:0] given_name_high;
        logic [63:0] surname_low;
        logic [15:0] surname_high;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] out_number;
        logic [63:0] out_given_low;
        logic [15:0] out_given_high;
        logic [63:0] out_surname_low;
        logic [15:0] out_surname_high;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [30:0] number;
        logic [63:0] given_low;
        logic [15:0] given_high;
        logic [63:0] surname_low;
        logic [15:0] surname_high;
    } t_rec;

    typedef struct packed {
        t_kind kind;
        t_rec  rec;
    } t_item;

endpackage

>>> src/linked_stack_queue_transfer.sv
// Top level of the linked stack and queue transfer block.
// Depends on lsq_pkg, lsq_front, lsq_back and (through lsq_back) lsq_ram.
`timescale 1ns / 1ps
// The block keeps a pool of POOL_DEPTH student records threaded into a stack
// and a queue through one link memory. Commands arrive as input transfers and
// are decoded into a two-entry queue, so the input keeps taking commands while
// the execution side is busy. A load or a failed command yields one result
// transfer. A move does a registered read of the link memory followed by
// one or two link writes, then yields one result. A listing yields one result
// per record, found by the walk through the link memory one node per read;
// the last result of every command carries last_of_run. Results wait in an
// output register, so a stalled output does not block command intake until
// the front queue fills.
// Unknown command codes are accepted and dropped without a result. Record
// stores are not cleared at reset; they are only ever read after being written.
module linked_stack_queue_transfer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lsq_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lsq_pkg::t_out o_out
);

    logic           item_valid;
    logic           item_pop;
    lsq_pkg::t_item item;

    // Decode and buffer incoming commands.
    lsq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_item_valid(item_valid), .o_item(item), .i_item_pop(item_pop)
    );

    // Execute commands against the node pool and drive the result port.
    lsq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item_valid(item_valid), .i_item(item), .o_item_pop(item_pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

endmodule

>>> src/lsq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the record and link stores.
`timescale 1ns / 1ps
module lsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lsq_front.sv
// Front end: accepts command transfers, decodes the command class and holds
// them in a two-entry queue for the back end. Depends on lsq_pkg.
`timescale 1ns / 1ps
module lsq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lsq_pkg::t_in  i_in,
    output logic          o_item_valid,
    output lsq_pkg::t_item o_item,
    input  logic          i_item_pop
);

    lsq_pkg::t_item r_buf [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    lsq_pkg::t_kind kind;
    logic           push;

    always_comb begin
        unique case (i_in.command)
            lsq_pkg::CMD_PUSH:       kind = lsq_pkg::K_PUSH;
            lsq_pkg::CMD_ENQUEUE:    kind = lsq_pkg::K_ENQ;
            lsq_pkg::CMD_STACK2QUE:  kind = lsq_pkg::K_S2Q;
            lsq_pkg::CMD_QUE2STACK:  kind = lsq_pkg::K_Q2S;
            lsq_pkg::CMD_LIST_STACK: kind = lsq_pkg::K_LSTK;
            lsq_pkg::CMD_LIST_QUEUE: kind = lsq_pkg::K_LQUE;
            default:                 kind = lsq_pkg::K_NONE;
        endcase
    end

    assign o_in_stall   = (r_cnt == 2'd2);
    // Unknown commands are taken and dropped here; they cause no result.
    assign push         = i_in_valid && !o_in_stall && (kind != lsq_pkg::K_NONE);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp].kind              <= kind;
            r_buf[r_wp].rec.number       <= i_in.record_number;
            r_buf[r_wp].rec.given_low    <= i_in.given_name_low;
            r_buf[r_wp].rec.given_high   <= i_in.given_name_high;
            r_buf[r_wp].rec.surname_low  <= i_in.surname_low;
            r_buf[r_wp].rec.surname_high <= i_in.surname_high;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_item_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_item_pop};
        end
    end

endmodule

>>> src/lsq_back.sv
// Back end: executes loads, moves and listings on the node pool and drives
// the registered result port. Depends on lsq_pkg and lsq_ram.
`timescale 1ns / 1ps
module lsq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  lsq_pkg::t_item i_item,
    output logic           o_item_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lsq_pkg::t_out  o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOVE  = 5'b00010,
        S_LINK2 = 5'b00100,
        S_LWAIT = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [lsq_pkg::PW-1:0] r_top, n_top, r_front, n_front, r_back, n_back;
    logic [lsq_pkg::PW-1:0] r_node, n_node, r_wa, n_wa, r_wd, n_wd;
    logic [lsq_pkg::CW-1:0] r_scnt, n_scnt, r_qcnt, n_qcnt, r_used, n_used;
    logic [lsq_pkg::CW-1:0] r_left, n_left;
    lsq_pkg::t_kind         r_kind, n_kind;
    lsq_pkg::t_out          r_res, n_res, r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic                   rec_we, lnk_we;
    logic [lsq_pkg::PW-1:0] lnk_wa, lnk_wd, rd_addr, lnk_q, new_node;
    lsq_pkg::t_rec          rec_q;
    logic                   out_free;

    lsq_ram #(.WIDTH($bits(lsq_pkg::t_rec)), .DEPTH(lsq_pkg::POOL_DEPTH)) u_rec (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(new_node), .i_wdata(i_item.rec),
        .i_raddr(rd_addr), .o_rdata(rec_q)
    );

    lsq_ram #(.WIDTH(lsq_pkg::PW), .DEPTH(lsq_pkg::POOL_DEPTH)) u_link (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_wa), .i_wdata(lnk_wd),
        .i_raddr(rd_addr), .o_rdata(lnk_q)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign new_node = r_used[lsq_pkg::PW-1:0];

    function automatic lsq_pkg::t_out status_res(input logic [1:0] st);
        lsq_pkg::t_out r;
        r             = '0;
        r.status      = st;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    function automatic lsq_pkg::t_out rec_res(input lsq_pkg::t_rec rec, input logic last);
        lsq_pkg::t_out r;
        r.status           = lsq_pkg::ST_OK;
        r.out_number       = rec.number;
        r.out_given_low    = rec.given_low;
        r.out_given_high   = rec.given_high;
        r.out_surname_low  = rec.surname_low;
        r.out_surname_high = rec.surname_high;
        r.last_of_run      = last;
        return r;
    endfunction

    function automatic logic [lsq_pkg::CW-1:0] cap(input logic [lsq_pkg::CW-1:0] c);
        return (c > lsq_pkg::CW'(lsq_pkg::LIST_CAP)) ? lsq_pkg::CW'(lsq_pkg::LIST_CAP) : c;
    endfunction

    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_front     = r_front;
        n_back      = r_back;
        n_node      = r_node;
        n_wa        = r_wa;
        n_wd        = r_wd;
        n_scnt      = r_scnt;
        n_qcnt      = r_qcnt;
        n_used      = r_used;
        n_left      = r_left;
        n_kind      = r_kind;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_item_pop  = 1'b0;
        rec_we      = 1'b0;
        lnk_we      = 1'b0;
        lnk_wa      = r_node;
        lnk_wd      = '0;
        rd_addr     = r_node;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_kind     = i_item.kind;
                    n_state    = S_OUT;
                    case (i_item.kind)
                        lsq_pkg::K_PUSH, lsq_pkg::K_ENQ: begin
                            if (r_used == lsq_pkg::CW'(lsq_pkg::POOL_DEPTH)) begin
                                n_res = status_res(lsq_pkg::ST_FULL);
                            end else begin
                                rec_we = 1'b1;
                                lnk_we = 1'b1;
                                lnk_wa = new_node;
                                n_used = r_used + 1'b1;
                                n_res  = rec_res(i_item.rec, 1'b1);
                                if (i_item.kind == lsq_pkg::K_PUSH) begin
                                    // A push onto an empty stack ends the chain.
                                    lnk_wd = (r_scnt == '0) ? '0 : r_top;
                                    n_top  = new_node;
                                    n_scnt = r_scnt + 1'b1;
                                end else begin
                                    if (r_qcnt == '0) begin
                                        n_front = new_node;
                                    end else begin
                                        n_wa    = r_back;
                                        n_wd    = new_node;
                                        n_state = S_LINK2;
                                    end
                                    n_back = new_node;
                                    n_qcnt = r_qcnt + 1'b1;
                                end
                            end
                        end
                        lsq_pkg::K_S2Q, lsq_pkg::K_LSTK: begin
                            if (r_scnt == '0) begin
                                n_res = status_res(lsq_pkg::ST_EMPTY);
                            end else begin
                                rd_addr = r_top;
                                n_node  = r_top;
                                if (i_item.kind == lsq_pkg::K_S2Q) begin
                                    n_state = S_MOVE;
                                end else begin
                                    n_left  = cap(r_scnt);
                                    n_state = S_LWAIT;
                                end
                            end
                        end
                        default: begin
                            if (r_qcnt == '0) begin
                                n_res = status_res(lsq_pkg::ST_EMPTY);
                            end else begin
                                rd_addr = r_front;
                                n_node  = r_front;
                                if (i_item.kind == lsq_pkg::K_Q2S) begin
                                    n_state = S_MOVE;
                                end else begin
                                    n_left  = cap(r_qcnt);
                                    n_state = S_LWAIT;
                                end
                            end
                        end
                    endcase
                end
            end
            S_MOVE: begin
                n_res   = rec_res(rec_q, 1'b1);
                lnk_we  = 1'b1;
                lnk_wa  = r_node;
                n_state = S_OUT;
                if (r_kind == lsq_pkg::K_S2Q) begin
                    n_top  = lnk_q;
                    n_scnt = r_scnt - 1'b1;
                    lnk_wd = '0;
                    if (r_qcnt == '0) begin
                        n_front = r_node;
                    end else begin
                        n_wa    = r_back;
                        n_wd    = r_node;
                        n_state = S_LINK2;
                    end
                    n_back = r_node;
                    n_qcnt = r_qcnt + 1'b1;
                end else begin
                    n_front = lnk_q;
                    n_qcnt  = r_qcnt - 1'b1;
                    lnk_wd  = (r_scnt == '0) ? '0 : r_top;
                    n_top   = r_node;
                    n_scnt  = r_scnt + 1'b1;
                end
            end
            S_LINK2: begin
                lnk_we  = 1'b1;
                lnk_wa  = r_wa;
                lnk_wd  = r_wd;
                n_state = S_OUT;
            end
            S_LWAIT: begin
                n_res   = rec_res(rec_q, r_left == lsq_pkg::CW'(1));
                n_node  = lnk_q;
                n_left  = r_left - 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    if (r_left != '0) begin
                        rd_addr = r_node;
                        n_state = S_LWAIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_wa   <= n_wa;
        r_wd   <= n_wd;
        r_kind <= n_kind;
        r_res  <= n_res;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_front     <= '0;
            r_back      <= '0;
            r_scnt      <= '0;
            r_qcnt      <= '0;
            r_used      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_front     <= n_front;
            r_back      <= n_back;
            r_scnt      <= n_scnt;
            r_qcnt      <= n_qcnt;
            r_used      <= n_used;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
